### sv/interval_sort_and_merge_assert.svh
// ----------------------------------------------------------------------------
// interval_sort_and_merge assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SORT_AND_MERGE_ASSERT_SVH
`define INTERVAL_SORT_AND_MERGE_ASSERT_SVH

// same-cycle implication
`define ISM_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ism assertion failed");

// next-cycle implication
`define ISM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ism assertion failed");

`endif

### sv/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg
// Shared constants and types of the interval sort and merge block.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int MaxIntervals = 64;
  localparam int BoundW       = 31;
  localparam int EntryW       = 2 * BoundW;

  typedef struct packed {
    logic we;
    logic re;
  } ism_mem_ctl_t;

endpackage

### sv/ism_mem.sv
// ----------------------------------------------------------------------------
// ism_mem
// Interval store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ism_mem #(
  parameter int DEPTH = ism_pkg::MaxIntervals,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  ism_pkg::ism_mem_ctl_t     ctl_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ism_pkg::EntryW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [ism_pkg::EntryW-1:0] rdata_o
);
  import ism_pkg::*;

  logic [EntryW-1:0] mem_q [DEPTH];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ism_ctrl.sv
// ----------------------------------------------------------------------------
// ism_ctrl
// Load, in-place insertion sort and merge sequencer with output register.
// ----------------------------------------------------------------------------
module ism_ctrl #(
  parameter int MAX_INTERVALS = ism_pkg::MaxIntervals,
  parameter int AW            = $clog2(MAX_INTERVALS),
  parameter int CW            = $clog2(MAX_INTERVALS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ism_pkg::BoundW-1:0] in_lower_i,
  input  logic [ism_pkg::BoundW-1:0] in_upper_i,
  input  logic                       in_end_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic [ism_pkg::BoundW-1:0] out_lower_o,
  output logic [ism_pkg::BoundW-1:0] out_upper_o,
  output logic                       out_final_o,
  output logic                       out_ovf_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ism_pkg::ism_mem_ctl_t      mem_ctl_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [ism_pkg::EntryW-1:0] mem_wdata_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [ism_pkg::EntryW-1:0] mem_rdata_i
);
  import ism_pkg::*;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_SKEY   = 4'd1;
  localparam logic [3:0] ST_SKEYW  = 4'd2;
  localparam logic [3:0] ST_SCMP   = 4'd3;
  localparam logic [3:0] ST_SPUT   = 4'd4;
  localparam logic [3:0] ST_MSTART = 4'd5;
  localparam logic [3:0] ST_MFIRST = 4'd6;
  localparam logic [3:0] ST_MEVAL  = 4'd7;
  localparam logic [3:0] ST_MFIN   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [AW-1:0]     i_q, i_d, k_q, k_d, j_q, j_d;
  logic [EntryW-1:0] key_q, key_d;
  logic [BoundW-1:0] cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
  logic              ov_q, ol_q, of_q;
  logic [BoundW-1:0] olo_q, ohi_q;
  logic              load_out, load_last;

  logic [BoundW-1:0] rd_lo, rd_hi, key_lo, key_hi;
  logic              out_free, key_before, overlap;
  logic [CW-1:0]     i_nx, j_nx;

  assign rd_lo  = mem_rdata_i[BoundW-1:0];
  assign rd_hi  = mem_rdata_i[EntryW-1:BoundW];
  assign key_lo = key_q[BoundW-1:0];
  assign key_hi = key_q[EntryW-1:BoundW];
  assign out_free   = !ov_q || out_ready_i;
  assign key_before = (key_lo < rd_lo) || ((key_lo == rd_lo) && (key_hi < rd_hi));
  assign overlap    = (cur_lo_q <= rd_hi) && (rd_lo <= cur_hi_q);
  assign i_nx = CW'(i_q) + 1'b1;
  assign j_nx = CW'(j_q) + 1'b1;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    k_d       = k_q;
    j_d       = j_q;
    key_d     = key_q;
    cur_lo_d  = cur_lo_q;
    cur_hi_d  = cur_hi_q;
    load_out  = 1'b0;
    load_last = 1'b0;
    mem_ctl_o   = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CW'(MAX_INTERVALS)) begin
            mem_ctl_o.we = 1'b1;
            mem_waddr_o  = cnt_q[AW-1:0];
            mem_wdata_o  = {in_upper_i, in_lower_i};
            cnt_d        = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_end_i) begin
            i_d     = AW'(1);
            state_d = ST_SKEY;
          end
        end
      end
      ST_SKEY: begin
        if (CW'(i_q) >= cnt_q) begin
          state_d = ST_MSTART;
        end else begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = i_q;
          state_d      = ST_SKEYW;
        end
      end
      ST_SKEYW: begin
        key_d        = mem_rdata_i;
        k_d          = i_q;
        mem_ctl_o.re = 1'b1;
        mem_raddr_o  = i_q - 1'b1;
        state_d      = ST_SCMP;
      end
      ST_SCMP: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = k_q;
        if (key_before) begin
          mem_wdata_o = mem_rdata_i;
          k_d         = k_q - 1'b1;
          if (k_q == AW'(1)) begin
            state_d = ST_SPUT;
          end else begin
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = k_q - AW'(2);
          end
        end else begin
          mem_wdata_o = key_q;
          i_d         = i_q + 1'b1;
          state_d     = (i_nx == cnt_q) ? ST_MSTART : ST_SKEY;
        end
      end
      ST_SPUT: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = '0;
        mem_wdata_o  = key_q;
        i_d          = i_q + 1'b1;
        state_d      = (i_nx == cnt_q) ? ST_MSTART : ST_SKEY;
      end
      ST_MSTART: begin
        mem_ctl_o.re = 1'b1;
        mem_raddr_o  = '0;
        state_d      = ST_MFIRST;
      end
      ST_MFIRST: begin
        cur_lo_d = rd_lo;
        cur_hi_d = rd_hi;
        j_d      = AW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = ST_MFIN;
        end else begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = AW'(1);
          state_d      = ST_MEVAL;
        end
      end
      ST_MEVAL: begin
        if (overlap || out_free) begin
          if (overlap) begin
            if (rd_lo < cur_lo_q) cur_lo_d = rd_lo;
            if (rd_hi > cur_hi_q) cur_hi_d = rd_hi;
          end else begin
            load_out = 1'b1;
            cur_lo_d = rd_lo;
            cur_hi_d = rd_hi;
          end
          if (j_nx == cnt_q) begin
            state_d = ST_MFIN;
          end else begin
            j_d          = j_q + 1'b1;
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = j_q + 1'b1;
          end
        end
      end
      ST_MFIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_last = 1'b1;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          state_d   = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    k_q      <= k_d;
    j_q      <= j_d;
    key_q    <= key_d;
    cur_lo_q <= cur_lo_d;
    cur_hi_q <= cur_hi_d;
    if (load_out) begin
      olo_q <= cur_lo_q;
      ohi_q <= cur_hi_q;
      ol_q  <= load_last;
      of_q  <= ovf_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_lower_o = olo_q;
  assign out_upper_o = ohi_q;
  assign out_final_o = ol_q;
  assign out_ovf_o   = of_q;

endmodule

### sv/interval_sort_and_merge.sv
// ----------------------------------------------------------------------------
// interval_sort_and_merge
// Collects closed intervals, sorts them and emits the merged intervals.
// ----------------------------------------------------------------------------
// Input stream: one interval per transaction; tlast closes the set. Intervals
// are taken one per cycle while the block is loading. After tlast the input
// stays not ready until the last merged interval has been loaded into the
// output register. Sorting is an in-place insertion sort on the interval
// memory, with up to n*(n-1)/2 shifts for n intervals; merging reads one
// entry per cycle while the output is free or the entry overlaps the
// current interval. The memory's single read port paces sort and merge.
// Output stream: merged intervals in increasing order, tlast on the last one,
// tuser carries the sticky overflow flag of the set. Intervals beyond
// MAX_INTERVALS are dropped. A stalled receiver holds the output register
// and pauses the merge. Reset empties the set and the output register.
// ----------------------------------------------------------------------------
module interval_sort_and_merge #(
  parameter int MAX_INTERVALS = ism_pkg::MaxIntervals
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [30:0] interval_lower, [61:31] interval_upper, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [30:0] merged_lower, [61:31] merged_upper, [63:62] zero
  output logic [63:0] m_axis_tdata,
  // [0] dropped_overflow
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);
  import ism_pkg::*;

  localparam int AW = $clog2(MAX_INTERVALS);

  ism_mem_ctl_t      mem_ctl;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [EntryW-1:0] mem_wdata, mem_rdata;
  logic [BoundW-1:0] out_lo, out_hi;
  logic              out_ovf;

  ism_mem #(
    .DEPTH (MAX_INTERVALS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ism_ctrl #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .AW            (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_lower_i  (s_axis_tdata[BoundW-1:0]),
    .in_upper_i  (s_axis_tdata[EntryW-1:BoundW]),
    .in_end_i    (s_axis_tlast),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_lower_o (out_lo),
    .out_upper_o (out_hi),
    .out_final_o (m_axis_tlast),
    .out_ovf_o   (out_ovf),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign m_axis_tdata = {2'b00, out_hi, out_lo};
  assign m_axis_tuser = out_ovf;

endmodule

### sv/ism_checker.sv
// ----------------------------------------------------------------------------
// ism_checker
// Port-level checks of the interval sort and merge block.
// ----------------------------------------------------------------------------
`include "interval_sort_and_merge_assert.svh"

module ism_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tlast
);

  `ISM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ISM_ASSERT_NEXT(a_busy_after_end, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  `ISM_ASSERT_NOW(a_busy_mid_set, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
  `ISM_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[63:62] == 2'b00)

endmodule

bind interval_sort_and_merge ism_checker u_ism_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

### bench/tb_interval_sort_and_merge.sv
// ----------------------------------------------------------------------------
// tb_interval_sort_and_merge
// Streams interval sets into the block and checks each merged interval, its
// tlast and its overflow flag against a sort-and-merge predictor.
// ----------------------------------------------------------------------------
module tb_interval_sort_and_merge;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMax = ism_pkg::MaxIntervals;
  localparam int BW   = ism_pkg::BoundW;

  typedef struct {
    logic [BW-1:0] lower;
    logic [BW-1:0] upper;
    logic          set_end;
  } ivl_item_t;

  typedef struct {
    logic [BW-1:0] lower;
    logic [BW-1:0] upper;
    logic          last;
    logic          ovf;
  } merged_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  interval_sort_and_merge i_dut (.*);

  always #5 clk_i = ~clk_i;

  ivl_item_t     pending_q[$];
  merged_t       merged_expect_q[$];
  logic [BW-1:0] set_lower[NMax];
  logic [BW-1:0] set_upper[NMax];
  int            set_count;
  bit            set_ovf;
  int            mismatches;
  int            results_seen;
  int            sets_done;
  int            cycle_cnt;
  int            items_added;
  bit            hold_until_drained;

  function automatic bit ivl_precedes(logic [BW-1:0] la, logic [BW-1:0] ua,
                                      logic [BW-1:0] lb, logic [BW-1:0] ub);
    if (la != lb) return la < lb;
    return ua < ub;
  endfunction

  // absorb one accepted interval; on set end sort, merge and queue results
  task automatic predict_merge(ivl_item_t it);
    logic [BW-1:0] lo, hi, cl, ch;
    int k;
    merged_t r;
    if (set_count < NMax) begin
      set_lower[set_count] = it.lower;
      set_upper[set_count] = it.upper;
      set_count++;
    end else begin
      set_ovf = 1'b1;
    end
    if (!it.set_end) return;
    for (int i = 1; i < set_count; i++) begin
      lo = set_lower[i];
      hi = set_upper[i];
      k = i;
      while (k > 0 && ivl_precedes(lo, hi, set_lower[k-1], set_upper[k-1])) begin
        set_lower[k] = set_lower[k-1];
        set_upper[k] = set_upper[k-1];
        k--;
      end
      set_lower[k] = lo;
      set_upper[k] = hi;
    end
    cl = set_lower[0];
    ch = set_upper[0];
    for (int i = 1; i < set_count; i++) begin
      if (cl <= set_upper[i] && set_lower[i] <= ch) begin
        if (set_lower[i] < cl) cl = set_lower[i];
        if (set_upper[i] > ch) ch = set_upper[i];
      end else begin
        r = '{cl, ch, 1'b0, set_ovf};
        merged_expect_q.push_back(r);
        cl = set_lower[i];
        ch = set_upper[i];
      end
    end
    r = '{cl, ch, 1'b1, set_ovf};
    merged_expect_q.push_back(r);
    set_count = 0;
    set_ovf = 1'b0;
  endtask

  // driver
  int        src_wait;
  ivl_item_t cur_item;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_merge(cur_item);
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (src_wait > 0) begin
        src_wait <= src_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0 && !(hold_until_drained &&
                   (merged_expect_q.size() > 0 || (s_axis_tvalid && s_axis_tlast)))) begin
        cur_item = pending_q.pop_front();
        s_axis_tdata <= {2'b00, cur_item.upper, cur_item.lower};
        s_axis_tlast <= cur_item.set_end;
        s_axis_tvalid <= 1'b1;
        src_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  int      snk_wait;
  merged_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (merged_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          exp_r = merged_expect_q.pop_front();
          if (m_axis_tdata[BW-1:0] !== exp_r.lower || m_axis_tdata[2*BW-1:BW] !== exp_r.upper
              || m_axis_tlast !== exp_r.last || m_axis_tuser[0] !== exp_r.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp lo=%0d hi=%0d last=%0b ovf=%0b, got lo=%0d hi=%0d last=%0b ovf=%0b",
                       exp_r.lower, exp_r.upper, exp_r.last, exp_r.ovf, m_axis_tdata[BW-1:0],
                       m_axis_tdata[2*BW-1:BW], m_axis_tlast, m_axis_tuser[0]);
          end
          if (exp_r.last) sets_done++;
        end
      end
      if (snk_wait > 0) begin
        snk_wait <= snk_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid)
          snk_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 900000) begin
      $display("interval_sort_and_merge regression: fail");
      $finish;
    end
  end

  task automatic add_item(logic [BW-1:0] lo, logic [BW-1:0] hi, logic e);
    ivl_item_t it;
    it = '{lo, hi, e};
    pending_q.push_back(it);
    items_added++;
  endtask

  task automatic add_random_set(int n, int span);
    logic [BW-1:0] lo, hi;
    for (int i = 0; i < n; i++) begin
      lo = (span == 0) ? BW'($urandom) : BW'($urandom_range(0, span));
      hi = ($urandom_range(0, 9) == 0) ? lo - BW'($urandom_range(0, 3))
                                       : lo + BW'($urandom_range(0, span / 4 + 1));
      add_item(lo, hi, i == n - 1);
    end
  endtask

  initial begin
    int n;
    src_wait = 0; snk_wait = 0; set_count = 0; set_ovf = 0;
    mismatches = 0; results_seen = 0; sets_done = 0; cycle_cnt = 0;
    items_added = 0;
    hold_until_drained = 0;
    // single interval, extremes
    add_item('0, '1, 1'b1);
    add_item('1, '1, 1'b1);
    add_item('0, '0, 1'b1);
    // touching, disjoint, inverted, duplicates, ties
    add_item(10, 20, 1'b0);
    add_item(20, 30, 1'b0);
    add_item(40, 50, 1'b0);
    add_item(60, 55, 1'b0);
    add_item(40, 45, 1'b0);
    add_item(40, 45, 1'b0);
    add_item(5, 7, 1'b1);
    add_item(31'h2AAAAAAA, 31'h55555555, 1'b0);
    add_item(31'h55555555, 31'h2AAAAAAA, 1'b1);
    repeat (4) begin
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      add_random_set(n, $urandom_range(0, 1) ? 200 : 0);
    end
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    // sender holds off until every result has come, then an overflowed set
    hold_until_drained = 1;
    add_random_set(NMax + 3, 1000);
    wait (pending_q.size() == 0);
    hold_until_drained = 0;
    while (items_added < 120) add_random_set($urandom_range(1, 10),
                                             $urandom_range(0, 1) ? 100 : 0);
    wait (pending_q.size() == 0 && !s_axis_tvalid && merged_expect_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d sets and %0d merged intervals, including overflowed sets",
             sets_done, results_seen);
    if (mismatches == 0 && merged_expect_q.size() == 0)
      $display("interval_sort_and_merge regression: pass");
    else
      $display("interval_sort_and_merge regression: fail");
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/ism_pkg.sv
sv/ism_mem.sv
sv/ism_ctrl.sv
sv/interval_sort_and_merge.sv
sv/ism_checker.sv
bench/tb_interval_sort_and_merge.sv
